/* hdl/pcbp_pkg.sv */
// Shared types, constants and request codes for the prefix code bit packer.
// No dependencies; every other design file of the block but the checker imports it.
`timescale 1ns / 1ps

package pcbp_pkg;

  // table geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
  localparam int SYM_W        = 8;
  localparam int WORD_W       = 32;
  localparam int LEN_W        = 6;
  localparam int PEND_W       = 7;
  localparam int CNT_W        = 3;
  localparam int MAX_BYTES    = 4;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_ENCODE   = 2'd1;
  localparam logic [1:0] REQ_FLUSH    = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // one code table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } code_entry_t;

  // bytes handed from the packer to the output buffer
  typedef struct packed {
    logic                push;
    logic [2:0]          count;
    logic [MAX_BYTES-1:0][7:0] bytes;
  } pcbp_burst_t;

endpackage

/* hdl/pcbp_code_mem.sv */
// Code table memory: one write and one registered read port, with valid bits.
// Depends on pcbp_pkg for the table geometry and entry type.
`timescale 1ns / 1ps

module pcbp_code_mem
  import pcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  code_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output code_entry_t       rd_data
);

  code_entry_t             mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;
  code_entry_t             rd_raw;
  logic                    rd_vld;

  // table storage, written on load requests
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits so that an unloaded entry reads as an empty code
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered read, held while no new lookup is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_comb begin
    rd_data      = rd_raw;
    rd_data.len  = rd_vld ? rd_raw.len : '0;
  end

endmodule

/* hdl/pcbp_packer.sv */
// Lookup stage and bit accumulator: appends code bits and cuts whole bytes.
// Depends on pcbp_pkg; reads the code table result from pcbp_code_mem.
`timescale 1ns / 1ps

module pcbp_packer
  import pcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [1:0]  take_req,
  output logic        ready,
  input  code_entry_t entry,
  input  logic        buf_free,
  output pcbp_burst_t burst
);

  logic              s1_valid;
  logic [1:0]        s1_req;
  logic [PEND_W-1:0] pend;
  logic [CNT_W-1:0]  pend_cnt;
  logic [PEND_W-1:0] pend_next;
  logic [CNT_W-1:0]  pend_cnt_next;
  logic [2:0]        n_bytes;
  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [WORD_W:0]   word_mask;
  logic [WORD_W-1:0] word_m;
  logic [38:0]       acc;
  logic [LEN_W-1:0]  total;
  logic [39:0]       aligned;
  logic              go;

  // append the looked-up code, or form the padded flush byte
  always_comb begin
    word_mask     = (33'd1 << entry.len) - 33'd1;
    word_m        = entry.word & word_mask[WORD_W-1:0];
    acc           = (39'(pend) << entry.len) | 39'(word_m);
    total         = LEN_W'(pend_cnt) + entry.len;
    aligned       = 40'(acc) << (6'd40 - total);
    n_bytes       = 3'd0;
    bytes         = '0;
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    case (s1_req)
      REQ_ENCODE: begin
        n_bytes = total[5:3];
        for (int k = 0; k < MAX_BYTES; k++) begin
          bytes[k] = aligned[39-8*k -: 8];
        end
        pend_next     = acc[PEND_W-1:0] & ((7'd1 << total[2:0]) - 7'd1);
        pend_cnt_next = total[2:0];
      end
      REQ_FLUSH: begin
        n_bytes       = (pend_cnt != '0) ? 3'd1 : 3'd0;
        bytes[0]      = 8'(15'(pend) << (4'd8 - 4'(pend_cnt)));
        pend_next     = '0;
        pend_cnt_next = '0;
      end
      default: begin
        n_bytes = 3'd0;
      end
    endcase
  end

  // an item with no bytes never waits for the output buffer
  assign go    = s1_valid && ((n_bytes == 3'd0) || buf_free);
  assign ready = !s1_valid || go;

  assign burst.push  = go && (n_bytes != 3'd0);
  assign burst.count = n_bytes;
  assign burst.bytes = bytes;

  // stage valid and request kind
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_req   <= REQ_LOAD;
    end else if (take) begin
      s1_valid <= 1'b1;
      s1_req   <= take_req;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  // bit accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      pend_cnt <= '0;
    end else if (go) begin
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end
  end

endmodule

/* hdl/pcbp_out_buf.sv */
// Output buffer: holds up to four bytes of one request, sends one a cycle while ready.
// Depends on pcbp_pkg for the burst type.
`timescale 1ns / 1ps

module pcbp_out_buf
  import pcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pcbp_burst_t burst,
  output logic        buf_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [2:0]                cnt;
  logic [1:0]                idx;
  logic                      sent;

  assign out_valid = (cnt != 3'd0);
  assign out_last  = (3'(idx) == cnt - 3'd1);
  assign out_byte  = bytes[idx];
  assign sent      = out_valid && out_ready;
  assign buf_free  = !out_valid || (sent && out_last);

  // byte store, loaded whole from the packer
  always_ff @(posedge clk) begin
    if (burst.push) begin
      bytes <= burst.bytes;
    end
  end

  // fill count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (burst.push) begin
      cnt <= burst.count;
      idx <= '0;
    end else if (sent) begin
      if (out_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

/* hdl/prefix_code_bit_packer.sv */
// Prefix code encoder with byte packing; top level of the block.
// Instantiates pcbp_code_mem, pcbp_packer and pcbp_out_buf; uses pcbp_pkg.
`timescale 1ns / 1ps

// Prefix code (Huffman) encoder. A load request (tuser 0) writes one symbol's
// code word and length into the 256-entry code table; an encode request
// (tuser 1) looks up its symbol and appends the code bits, first bit first,
// to a bit accumulator, and every finished byte leaves on the master stream
// earliest bit in the MSB; a flush request (tuser 2) sends the partial byte
// padded with zeros and clears the accumulator. tlast marks the final byte
// of each request; requests that give no byte give no beat. One request is
// taken every cycle while each gives at most one byte and m_tready is high:
// the output buffer sends one byte a cycle, so a request giving several
// bytes holds the next byte-giving request until its last byte is sent.
// The first byte passes the lookup stage register (the table read) and the
// output buffer register; packing between them is combinational. Unloaded
// entries read as empty codes straight after reset, no clearing pass is needed.

module prefix_code_bit_packer
  import pcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40], zeros
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte[7:0]
  output logic        m_tlast   // last_of_run
);

  logic [SYM_W-1:0]  sym;
  logic [WORD_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_len;
  logic              sym_ok;
  logic              accept;
  logic              is_load;
  logic              is_encode;
  logic              is_flush;
  code_entry_t       wr_entry;
  code_entry_t       entry;
  pcbp_burst_t       burst;
  logic              buf_free;

  assign sym       = s_tdata[7:0];
  assign code_bits = s_tdata[39:8];
  assign code_len  = s_tdata[45:40];
  assign sym_ok    = (9'(sym) < 9'(SYMBOL_COUNT));
  assign accept    = s_tvalid && s_tready;

  // request decode
  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (s_tuser)
      REQ_LOAD:   is_load   = 1'b1;
      REQ_ENCODE: is_encode = 1'b1;
      REQ_FLUSH:  is_flush  = 1'b1;
      default:    is_load   = 1'b0;
    endcase
  end

  // saturate the loaded length to the longest supported code
  always_comb begin
    wr_entry.word = code_bits;
    if (code_len > LEN_W'(MAX_CODE_LEN)) begin
      wr_entry.len = LEN_W'(MAX_CODE_LEN);
    end else begin
      wr_entry.len = code_len;
    end
    if (wr_entry.len > LEN_W'(WORD_W)) begin
      wr_entry.len = LEN_W'(WORD_W);
    end
  end

  pcbp_code_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && is_load && sym_ok),
    .wr_addr (sym[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (accept && is_encode && sym_ok),
    .rd_addr (sym[ADDR_W-1:0]),
    .rd_data (entry)
  );

  pcbp_packer u_pack (
    .clk      (clk),
    .rst      (rst),
    .take     (accept && ((is_encode && sym_ok) || is_flush)),
    .take_req (s_tuser),
    .ready    (s_tready),
    .entry    (entry),
    .buf_free (buf_free),
    .burst    (burst)
  );

  pcbp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .buf_free  (buf_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* hdl/pcbp_checker.sv */
// Port-level checks for the prefix code bit packer, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module pcbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  logic s_acc;

  assign s_acc = s_tvalid && s_tready;

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output byte changed while stalled");

  // after reset the block is empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // with no request and nothing in flight, no byte appears from nowhere
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!s_acc && !m_tvalid) ##1 (!s_acc && !m_tvalid) |=> !m_tvalid)
    else $error("output byte with no request in flight");

  // an idle output side never blocks the input
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && $past(!m_tvalid) && !$past(s_acc) |-> s_tready)
    else $error("input blocked while output idle");

endmodule

bind prefix_code_bit_packer pcbp_checker u_chk (.*);
